[rtl/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

	localparam int PIXEL_WORDS = 512;
	localparam int ADDR_W = (PIXEL_WORDS > 1) ? $clog2(PIXEL_WORDS) : 1;
	localparam int FILL_W = $clog2(PIXEL_WORDS + 1);
	localparam int RIDX_W = 9;
	localparam int WORD_W = 32;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [7:0] FRAME_END = 8'hC0;
	localparam logic [7:0] ESC_MARK  = 8'hDB;
	localparam logic [7:0] ESC_END   = 8'hDC;
	localparam logic [7:0] ESC_ESC   = 8'hDD;

	localparam logic [1:0] LANE_TOP = 2'd0;
	localparam logic [1:0] LANE_MID = 2'd1;
	localparam logic [1:0] LANE_LOW = 2'd2;

	typedef struct packed {
		logic              valid;
		logic              is_rd;
		logic              zero;
		logic [ADDR_W-1:0] addr;
		logic [1:0]        lane;
		logic [7:0]        data;
		logic [RIDX_W-1:0] ridx;
	} sfr_req_t;

	typedef struct packed {
		logic [RIDX_W-1:0] word_index;
		logic [WORD_W-1:0] pixel_word;
	} sfr_rsp_t;

endpackage

`default_nettype wire

[rtl/sfr_decode.sv]
`default_nettype none

module sfr_decode (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic                      opcode,
	input  wire logic [7:0]                rx_byte,
	input  wire logic [sfr_pkg::RIDX_W-1:0] read_index,
	output sfr_pkg::sfr_req_t              req
);
	import sfr_pkg::*;

	logic [ADDR_W-1:0] idx_q, idx_n;
	logic [1:0]        lane_q, lane_n, lane_eff;
	logic [FILL_W-1:0] fill_q;
	logic              seen_q, seen_n, esc_q, esc_n;
	logic              store;
	logic [7:0]        sbyte;
	logic              fresh;

	assign lane_eff = (lane_q inside {LANE_MID, LANE_LOW}) ? lane_q : LANE_TOP;
	assign fresh = (FILL_W'(idx_q) == fill_q);

	always_comb begin
		store  = 1'b0;
		sbyte  = rx_byte;
		seen_n = seen_q;
		esc_n  = esc_q;
		idx_n  = idx_q;
		lane_n = lane_eff;
		if (opcode == OP_BYTE) begin
			case (rx_byte)
				FRAME_END: begin
					seen_n = 1'b1;
					idx_n  = '0;
					lane_n = LANE_TOP;
				end
				ESC_MARK: begin
					if (seen_q || esc_q) begin
						esc_n = 1'b1;
					end
				end
				ESC_END: begin
					store = 1'b1;
					if (seen_q && esc_q) begin
						sbyte = FRAME_END;
						esc_n = 1'b0;
					end
				end
				ESC_ESC: begin
					store = 1'b1;
					if (esc_q) begin
						sbyte = ESC_MARK;
						esc_n = 1'b0;
					end
				end
				default: begin
					store = seen_q;
				end
			endcase
			if (store) begin
				if (lane_eff == LANE_LOW) begin
					lane_n = LANE_TOP;
					idx_n  = (idx_q == ADDR_W'(PIXEL_WORDS - 1)) ? '0 : idx_q + 1'b1;
				end else begin
					lane_n = lane_eff + 2'd1;
				end
			end
		end
	end

	always_comb begin
		req.valid = accept && (opcode == OP_READ || store);
		req.is_rd = (opcode == OP_READ);
		req.lane  = lane_eff;
		req.data  = sbyte;
		req.ridx  = read_index;
		if (opcode == OP_READ) begin
			req.addr = ADDR_W'(read_index);
			req.zero = (32'(read_index) >= 32'(fill_q));
		end else begin
			req.addr = idx_q;
			req.zero = fresh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			lane_q <= LANE_TOP;
			seen_q <= 1'b0;
			esc_q  <= 1'b0;
			fill_q <= '0;
		end else if (accept && opcode == OP_BYTE) begin
			idx_q  <= idx_n;
			lane_q <= lane_n;
			seen_q <= seen_n;
			esc_q  <= esc_n;
			if (store && fresh) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/sfr_store.sv]
`default_nettype none

module sfr_store (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfr_pkg::sfr_req_t req,
	output logic                   rd_pend_s1,
	output logic                   rsp_valid,
	output sfr_pkg::sfr_rsp_t      rsp
);
	import sfr_pkg::*;

	logic [WORD_W-1:0] mem [PIXEL_WORDS];
	logic [WORD_W-1:0] rdata_s1;
	logic              valid_s1, is_rd_s1, zero_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [1:0]        lane_s1;
	logic [7:0]        data_s1;
	logic [RIDX_W-1:0] ridx_s1;
	logic              byp_valid_q;
	logic [ADDR_W-1:0] byp_addr_q;
	logic [WORD_W-1:0] byp_data_q;
	logic [WORD_W-1:0] base, merged;
	logic              wr_en;

	always_comb begin
		if (zero_s1) begin
			base = '0;
		end else if (byp_valid_q && byp_addr_q == addr_s1) begin
			base = byp_data_q;
		end else begin
			base = rdata_s1;
		end
		case (lane_s1)
			LANE_MID: merged = {base[31:24], data_s1, base[15:0]};
			LANE_LOW: merged = {base[31:16], data_s1, base[7:0]};
			default:  merged = {data_s1, base[23:0]};
		endcase
	end

	assign wr_en = valid_s1 && !is_rd_s1;
	assign rd_pend_s1 = valid_s1 && is_rd_s1;
	assign rsp_valid = rd_pend_s1;
	assign rsp = '{word_index: ridx_s1, pixel_word: base};

	always_ff @(posedge clk) begin
		if (req.valid) begin
			rdata_s1 <= mem[req.addr];
		end
		if (wr_en) begin
			mem[addr_s1] <= merged;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			is_rd_s1 <= req.is_rd;
			zero_s1  <= req.zero;
			addr_s1  <= req.addr;
			lane_s1  <= req.lane;
			data_s1  <= req.data;
			ridx_s1  <= req.ridx;
		end
		if (wr_en) begin
			byp_addr_q <= addr_s1;
			byp_data_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			byp_valid_q <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			if (wr_en) begin
				byp_valid_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/sfr_outq.sv]
`default_nettype none

module sfr_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sfr_pkg::sfr_rsp_t push_data,
	input  wire logic              rd_pend,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sfr_pkg::sfr_rsp_t      out_data
);
	import sfr_pkg::*;

	sfr_rsp_t              entry_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0]   cnt_q;
	logic                  pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// Room is kept for the read in flight and for one more transfer.
	assign room = (32'(cnt_q) + 32'(rd_pend) + 32'd1) <= 32'(OQ_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/slip_pixel_frame_receiver.sv]
// A read transfer is registered in the store, then in the output queue.
// Throughput: one transfer per cycle while the queue has room; the pixel
// memory does one read and one write each cycle, and the last write is
// forwarded to a read of the same word. Reset clears the decoder state and
// the fill count; unwritten words read as zero, so memory needs no clearing.
`default_nettype none

module slip_pixel_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // rx_byte [7:0], read_index [16:8]
	input  wire logic [0:0]  s_tuser,   // opcode [0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // pixel_word [31:0], word_index [40:32]
);
	import sfr_pkg::*;

	sfr_req_t req;
	sfr_rsp_t rsp, out_rsp;
	logic     rsp_valid, rd_pend, room, accept;

	assign s_tready = room;
	assign accept   = s_tvalid && s_tready;

	sfr_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (s_tuser[0]),
		.rx_byte    (s_tdata[7:0]),
		.read_index (s_tdata[16:8]),
		.req        (req)
	);

	sfr_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rd_pend_s1 (rd_pend),
		.rsp_valid  (rsp_valid),
		.rsp        (rsp)
	);

	sfr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rsp_valid),
		.push_data (rsp),
		.rd_pend   (rd_pend),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_rsp)
	);

	assign m_tdata = {7'd0, out_rsp.word_index, out_rsp.pixel_word};

endmodule

`default_nettype wire

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTED = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;    // rx_byte [7:0], read_index [16:8]
	logic [0:0]  s_tuser = '0;    // opcode [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // pixel_word [31:0], word_index [40:32]

	logic [WORD_W-1:0] pix_mem [PIXEL_WORDS];
	int unsigned       wr_word;
	logic [1:0]        wr_lane;
	logic              in_frame;
	logic              esc_armed;
	sfr_rsp_t          pending_reads [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int reads_checked = 0;
	int mismatches = 0;
	int cycle_count = 0;

	slip_pixel_frame_receiver u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reads still pending",
				cycle_count, pending_reads.size());
			$display("[slip_pixel_frame_receiver] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch at cycle %0d: %s got %0h expected %0h",
				cycle_count, what, got, want);
	endtask

	always @(posedge clk) begin
		sfr_rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("unexpected read transfer", m_tdata, '0);
			end else begin
				want = pending_reads.pop_front();
				reads_checked++;
				if (m_tdata[31:0] !== want.pixel_word)
					report_mismatch("pixel_word", m_tdata[31:0], want.pixel_word);
				if (m_tdata[40:32] !== want.word_index)
					report_mismatch("word_index", m_tdata[40:32], want.word_index);
			end
		end
	end

	task automatic clear_model();
		foreach (pix_mem[i])
			pix_mem[i] = '0;
		wr_word = 0;
		wr_lane = LANE_TOP;
		in_frame = 1'b0;
		esc_armed = 1'b0;
	endtask

	task automatic put_byte(input logic [7:0] b);
		case (wr_lane)
			LANE_MID: pix_mem[wr_word][23:16] = b;
			LANE_LOW: pix_mem[wr_word][15:8] = b;
			default:  pix_mem[wr_word][31:24] = b;
		endcase
		if (wr_lane == LANE_LOW) begin
			wr_lane = LANE_TOP;
			wr_word = (wr_word == PIXEL_WORDS - 1) ? 0 : wr_word + 1;
		end else if (wr_lane == LANE_MID) begin
			wr_lane = LANE_LOW;
		end else begin
			wr_lane = LANE_MID;
		end
	endtask

	task automatic decode_transfer(input logic op, input logic [7:0] rx,
			input logic [RIDX_W-1:0] ridx);
		sfr_rsp_t want;
		if (op == OP_READ) begin
			want.word_index = ridx;
			want.pixel_word = (ridx < PIXEL_WORDS) ? pix_mem[ridx] : '0;
			pending_reads.push_back(want);
		end else begin
			case (rx)
				FRAME_END: begin
					in_frame = 1'b1;
					wr_word = 0;
					wr_lane = LANE_TOP;
				end
				ESC_MARK: begin
					if (in_frame || esc_armed)
						esc_armed = 1'b1;
				end
				ESC_END: begin
					if (in_frame && esc_armed) begin
						put_byte(FRAME_END);
						esc_armed = 1'b0;
					end else begin
						put_byte(ESC_END);
					end
				end
				ESC_ESC: begin
					if (esc_armed) begin
						put_byte(ESC_MARK);
						esc_armed = 1'b0;
					end else begin
						put_byte(ESC_ESC);
					end
				end
				default: begin
					if (in_frame)
						put_byte(rx);
				end
			endcase
		end
	endtask

	task automatic send_item(input logic op, input logic [7:0] rx,
			input logic [RIDX_W-1:0] ridx);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'b0, ridx, rx};
		do
			@(posedge clk);
		while (!s_tready);
		decode_transfer(op, rx, ridx);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(OP_BYTE, b, RIDX_W'($urandom_range(0, PIXEL_WORDS - 1)));
	endtask

	task automatic send_read(input int unsigned idx);
		send_item(OP_READ, 8'($urandom_range(0, 255)), RIDX_W'(idx));
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b inside {FRAME_END, ESC_MARK});
		return b;
	endfunction

	// Before any frame start only the two escape-code bytes (ESC_END, ESC_ESC) are stored.
	task automatic test_before_frame();
		send_read(0);
		send_read(PIXEL_WORDS - 1);
		send_byte(8'h41);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(ESC_MARK);
		send_byte(ESC_END);
		send_byte(ESC_ESC);
		send_read(0);
	endtask

	task automatic test_escapes();
		send_byte(FRAME_END);
		send_byte(8'hFF);
		send_byte(ESC_MARK);
		send_byte(ESC_END);
		send_byte(ESC_MARK);
		send_byte(ESC_ESC);
		send_byte(8'h00);
		send_byte(ESC_MARK);
		send_byte(ESC_MARK);
		send_byte(8'h55);
		send_byte(ESC_ESC);
		send_byte(ESC_END);
		send_read(0);
		send_read(1);
		send_byte(8'h12);
		send_byte(FRAME_END);
		send_byte(8'h34);
		send_read(0);
	endtask

	// A long frame fills a hundred words and the top byte of the next one.
	task automatic test_long_frame();
		send_byte(FRAME_END);
		repeat (301)
			send_byte(plain_byte());
		send_read(0);
		send_read(1);
		send_read(99);
		send_read(100);
		send_read(101);
		send_read(PIXEL_WORDS - 1);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int count);
		int stop_at;
		int pick;
		stop_at = items_sent + count;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_byte(FRAME_END);
				repeat ($urandom_range(0, 12)) begin
					case ($urandom_range(0, 9))
						0: begin
							send_byte(ESC_MARK);
							send_byte(ESC_END);
						end
						1: begin
							send_byte(ESC_MARK);
							send_byte(ESC_ESC);
						end
						2: send_read($urandom_range(0, 5));
						default: send_byte(plain_byte());
					endcase
				end
				repeat ($urandom_range(1, 3))
					send_read($urandom_range(0, 5));
			end else if (pick < 85) begin
				send_read($urandom_range(0, PIXEL_WORDS - 1));
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		clear_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_frame();
		test_escapes();
		test_long_frame();
		test_random_traffic(0, 0, 70);
		test_random_traffic(83, 0, 70);
		test_random_traffic(0, 83, 70);
		test_random_traffic(27, 27, 70);

		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d transfers and checked %0d pixel reads: escapes, frame restarts,",
			items_sent, reads_checked);
		$display("a long frame and four handshake pressure phases; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("[slip_pixel_frame_receiver] OK");
		end else begin
			$display("[slip_pixel_frame_receiver] ERROR");
		end
		$finish;
	end

endmodule
